### hw/rtl/cac_pkg.sv
// Shared types and constants for the circle / rectangle collision test.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package cac_pkg;

    // Pair kinds carried on the command field
    typedef enum logic [1:0] {
        CMD_CIRC_CIRC = 2'd0,
        CMD_CIRC_RECT = 2'd1,
        CMD_RECT_CIRC = 2'd2,
        CMD_RECT_RECT = 2'd3
    } cac_cmd_t;

    // Q1.14 unit and the diagonal component round(16384 / sqrt(2))
    localparam logic [15:0] ONE_Q14  = 16'd16384;
    localparam logic [15:0] DIAG_Q14 = 16'd11585;

    // Pipeline depths
    localparam int FRONT_STAGES = 5;
    localparam int DIV_STEPS    = 31;
    localparam int SQRT_STEPS   = 16;

    // Per-transaction control data that rides beside the normalizer
    typedef struct packed {
        cac_cmd_t          cmd;
        logic              hit;
        logic              zero;
        logic              neg_x;
        logic              neg_y;
        logic signed [1:0] rsx;
        logic signed [1:0] rsy;
    } cac_side_t;

endpackage

### hw/rtl/cac_front.sv
// Front stages: difference vector, clamp, exact hit test and normalizer setup.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_front (
    input  logic                aclk,
    input  logic                en,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  circle_x,
    input  logic signed [31:0]  circle_y,
    input  logic [30:0]         circle_r,
    input  logic signed [31:0]  other_x,
    input  logic signed [31:0]  other_y,
    input  logic [30:0]         other_r,
    input  logic signed [31:0]  rect_min_x,
    input  logic signed [31:0]  rect_min_y,
    input  logic signed [31:0]  rect_max_x,
    input  logic signed [31:0]  rect_max_y,
    output logic [31:0]         a_sq,
    output logic [31:0]         b_sq,
    output logic [32:0]         s_sum,
    output cac_pkg::cac_side_t  side
);

    // Stage 1 registers
    cac_pkg::cac_cmd_t  cmd1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic [31:0]        rad1_reg;
    logic signed [1:0]  rsx1_reg, rsy1_reg;
    // Stage 2 registers
    cac_pkg::cac_cmd_t  cmd2_reg;
    logic [31:0]        ax2_reg, ay2_reg, m2_reg, rad2_reg;
    logic               negx2_reg, negy2_reg;
    logic signed [1:0]  rsx2_reg, rsy2_reg;
    // Stage 3 registers
    cac_pkg::cac_cmd_t  cmd3_reg;
    logic [63:0]        sqx3_reg, sqy3_reg, sqr3_reg;
    logic [15:0]        a3_reg, b3_reg;
    logic               negx3_reg, negy3_reg;
    logic signed [1:0]  rsx3_reg, rsy3_reg;
    // Stage 4 registers
    cac_pkg::cac_cmd_t  cmd4_reg;
    logic               hit4_reg;
    logic [31:0]        a2_4_reg, b2_4_reg;
    logic               negx4_reg, negy4_reg;
    logic signed [1:0]  rsx4_reg, rsy4_reg;
    // Stage 5 registers
    logic [31:0]        a2_5_reg, b2_5_reg;
    logic [32:0]        s5_reg;
    cac_pkg::cac_side_t side5_reg;

    logic signed [31:0] clx, cly, clx_a, cly_a;
    logic signed [1:0]  sx, sy, sx_a, sy_a;
    logic signed [32:0] dx1_next, dy1_next;
    logic [31:0]        rad1_next;
    logic [31:0]        abx, aby;
    logic [4:0]         sh;
    logic [32:0]        s5_next;
    cac_pkg::cac_side_t side5_next;

    // Clamp the centre into the box, lower bound first, then upper bound
    always_comb begin
        clx_a = circle_x;
        sx_a  = 2'sd0;
        if (circle_x < rect_min_x) begin
            clx_a = rect_min_x;
            sx_a  = -2'sd1;
        end
        clx = clx_a;
        sx  = sx_a;
        if (clx_a > rect_max_x) begin
            clx = rect_max_x;
            sx  = 2'sd1;
        end
        cly_a = circle_y;
        sy_a  = 2'sd0;
        if (circle_y < rect_min_y) begin
            cly_a = rect_min_y;
            sy_a  = -2'sd1;
        end
        cly = cly_a;
        sy  = sy_a;
        if (cly_a > rect_max_y) begin
            cly = rect_max_y;
            sy  = 2'sd1;
        end
    end

    // Pick the difference vector and the radius bound by pair kind
    always_comb begin
        if (cac_pkg::cac_cmd_t'(cmd) == cac_pkg::CMD_CIRC_CIRC) begin
            dx1_next  = 33'(other_x) - 33'(circle_x);
            dy1_next  = 33'(other_y) - 33'(circle_y);
            rad1_next = {1'b0, circle_r} + {1'b0, other_r};
        end else begin
            dx1_next  = 33'(clx) - 33'(circle_x);
            dy1_next  = 33'(cly) - 33'(circle_y);
            rad1_next = {1'b0, circle_r};
        end
    end

    // Magnitudes of the difference; they always fit in 32 bits
    assign abx = dx1_reg[32] ? 32'(-dx1_reg) : 32'(dx1_reg);
    assign aby = dy1_reg[32] ? 32'(-dy1_reg) : 32'(dy1_reg);

    // Right shift that brings the larger magnitude below 2^16
    always_comb begin
        sh = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (m2_reg[16 + i]) sh = 5'(i + 1);
        end
    end

    assign s5_next = {1'b0, a2_4_reg} + {1'b0, b2_4_reg};

    always_comb begin
        side5_next.cmd   = cmd4_reg;
        side5_next.hit   = hit4_reg;
        side5_next.zero  = (s5_next == 33'd0);
        side5_next.neg_x = negx4_reg;
        side5_next.neg_y = negy4_reg;
        side5_next.rsx   = rsx4_reg;
        side5_next.rsy   = rsy4_reg;
    end

    // Advance all front stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= cac_pkg::cac_cmd_t'(cmd);
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            rad1_reg  <= rad1_next;
            rsx1_reg  <= sx;
            rsy1_reg  <= sy;

            cmd2_reg  <= cmd1_reg;
            ax2_reg   <= abx;
            ay2_reg   <= aby;
            m2_reg    <= (abx > aby) ? abx : aby;
            rad2_reg  <= rad1_reg;
            negx2_reg <= dx1_reg[32];
            negy2_reg <= dy1_reg[32];
            rsx2_reg  <= rsx1_reg;
            rsy2_reg  <= rsy1_reg;

            cmd3_reg  <= cmd2_reg;
            sqx3_reg  <= 64'(ax2_reg) * 64'(ax2_reg);
            sqy3_reg  <= 64'(ay2_reg) * 64'(ay2_reg);
            sqr3_reg  <= 64'(rad2_reg) * 64'(rad2_reg);
            a3_reg    <= 16'(ax2_reg >> sh);
            b3_reg    <= 16'(ay2_reg >> sh);
            negx3_reg <= negx2_reg;
            negy3_reg <= negy2_reg;
            rsx3_reg  <= rsx2_reg;
            rsy3_reg  <= rsy2_reg;

            cmd4_reg  <= cmd3_reg;
            hit4_reg  <= ({1'b0, sqx3_reg} + {1'b0, sqy3_reg}) <= {1'b0, sqr3_reg};
            a2_4_reg  <= 32'(a3_reg) * 32'(a3_reg);
            b2_4_reg  <= 32'(b3_reg) * 32'(b3_reg);
            negx4_reg <= negx3_reg;
            negy4_reg <= negy3_reg;
            rsx4_reg  <= rsx3_reg;
            rsy4_reg  <= rsy3_reg;

            a2_5_reg  <= a2_4_reg;
            b2_5_reg  <= b2_4_reg;
            s5_reg    <= s5_next;
            side5_reg <= side5_next;
        end
    end

    assign a_sq  = a2_5_reg;
    assign b_sq  = b2_5_reg;
    assign s_sum = s5_reg;
    assign side  = side5_reg;

endmodule

### hw/rtl/cac_div.sv
// Pipelined restoring divider: floor(num_sq * 2^30 / den), one quotient bit a stage.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num_sq,
    input  logic [32:0] den,
    output logic [30:0] quo
);

    logic [33:0] rem_reg [cac_pkg::DIV_STEPS];
    logic [30:0] q_reg   [cac_pkg::DIV_STEPS];
    logic [32:0] d_reg   [cac_pkg::DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < cac_pkg::DIV_STEPS; j++) begin : g_step
            logic [33:0] rem_in;
            logic [30:0] q_in;
            logic [32:0] d_in;
            logic        bit_in;
            logic [34:0] trial;
            logic        ge;

            // First stage seeds the remainder with the top bits of the dividend
            if (j == 0) begin : g_first
                assign rem_in = {3'b000, num_sq[31:1]};
                assign bit_in = num_sq[0];
                assign q_in   = '0;
                assign d_in   = den;
            end else begin : g_next
                assign rem_in = rem_reg[j-1];
                assign bit_in = 1'b0;
                assign q_in   = q_reg[j-1];
                assign d_in   = d_reg[j-1];
            end

            assign trial = {rem_in, bit_in};
            assign ge    = trial >= {2'b00, d_in};

            // Subtract when the divisor fits, shift in the quotient bit
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= ge ? 34'(trial - {2'b00, d_in}) : trial[33:0];
                    q_reg[j]   <= {q_in[29:0], ge};
                    d_reg[j]   <= d_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[cac_pkg::DIV_STEPS-1];

endmodule

### hw/rtl/cac_sqrt.sv
// Pipelined integer square root, two radicand bits a stage.
// Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [30:0] val,
    output logic [15:0] root
);

    logic [30:0] op_reg  [cac_pkg::SQRT_STEPS];
    logic [31:0] res_reg [cac_pkg::SQRT_STEPS];

    genvar j;
    generate
        for (j = 0; j < cac_pkg::SQRT_STEPS; j++) begin : g_step
            localparam logic [31:0] BIT_W = 32'd1 << (30 - 2 * j);
            logic [30:0] op_in;
            logic [31:0] res_in;
            logic [31:0] trial;
            logic        ge;

            if (j == 0) begin : g_first
                assign op_in  = val;
                assign res_in = '0;
            end else begin : g_next
                assign op_in  = op_reg[j-1];
                assign res_in = res_reg[j-1];
            end

            assign trial = res_in + BIT_W;
            assign ge    = {1'b0, op_in} >= trial;

            // Take the trial bit when it fits under the remaining radicand
            always_ff @(posedge aclk) begin
                if (en) begin
                    op_reg[j]  <= ge ? 31'({1'b0, op_in} - trial) : op_in;
                    res_reg[j] <= ge ? ((res_in >> 1) + BIT_W) : (res_in >> 1);
                end
            end
        end
    endgenerate

    assign root = res_reg[cac_pkg::SQRT_STEPS-1][15:0];

endmodule

### hw/rtl/circle_aabb_collision_test.sv
// Circle / circle and circle / axis-aligned rectangle collision test, top level.
// Depends on cac_pkg, cac_front, cac_div and cac_sqrt.
//
// One shape pair enters per transaction and one result leaves per transaction, in
// order. The block takes a new pair every cycle while no result is held back; each
// result passes through five front stages (clamp, magnitudes, squares, hit compare,
// sum of squares), a 31-stage divider that forms 2^30 * a^2 / S for each normal
// component, a 16-stage square root, and the output register. A stall on the
// result side freezes the whole pipeline, so nothing is dropped or repeated.
`timescale 1ns / 1ps

module circle_aabb_collision_test (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic signed [31:0]  s_circle_x,
    input  logic signed [31:0]  s_circle_y,
    input  logic [30:0]         s_circle_r,
    input  logic signed [31:0]  s_other_x,
    input  logic signed [31:0]  s_other_y,
    input  logic [30:0]         s_other_r,
    input  logic signed [31:0]  s_rect_min_x,
    input  logic signed [31:0]  s_rect_min_y,
    input  logic signed [31:0]  s_rect_max_x,
    input  logic signed [31:0]  s_rect_max_y,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic signed [15:0]  m_normal_a_x,
    output logic signed [15:0]  m_normal_a_y,
    output logic signed [15:0]  m_normal_b_x,
    output logic signed [15:0]  m_normal_b_y
);

    localparam int SIDE_DEPTH = cac_pkg::DIV_STEPS + cac_pkg::SQRT_STEPS;
    localparam int LATENCY    = cac_pkg::FRONT_STAGES + SIDE_DEPTH + 1;

    logic                en;
    logic [LATENCY-1:0]  vld_reg;
    logic [31:0]         a_sq, b_sq;
    logic [32:0]         s_sum;
    logic [30:0]         fa, fb;
    logic [15:0]         root_a, root_b;
    cac_pkg::cac_side_t  side_front;
    cac_pkg::cac_side_t  side_reg [SIDE_DEPTH];
    cac_pkg::cac_side_t  sd;

    logic [15:0]         qa, qb, rmag;
    logic signed [15:0]  cnx, cny, rnx, rny;
    logic                hit_next;
    logic signed [15:0]  nax_next, nay_next, nbx_next, nby_next;
    logic                hit_reg;
    logic signed [15:0]  nax_reg, nay_reg, nbx_reg, nby_reg;

    // Freeze every stage while a finished result waits
    assign en      = !(vld_reg[LATENCY-1] && !m_ready);
    assign s_ready = en;

    // Valid bits travel beside the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    cac_front u_front (
        .aclk       (aclk),
        .en         (en),
        .cmd        (s_cmd),
        .circle_x   (s_circle_x),
        .circle_y   (s_circle_y),
        .circle_r   (s_circle_r),
        .other_x    (s_other_x),
        .other_y    (s_other_y),
        .other_r    (s_other_r),
        .rect_min_x (s_rect_min_x),
        .rect_min_y (s_rect_min_y),
        .rect_max_x (s_rect_max_x),
        .rect_max_y (s_rect_max_y),
        .a_sq       (a_sq),
        .b_sq       (b_sq),
        .s_sum      (s_sum),
        .side       (side_front)
    );

    cac_div u_div_a (.aclk(aclk), .en(en), .num_sq(a_sq), .den(s_sum), .quo(fa));
    cac_div u_div_b (.aclk(aclk), .en(en), .num_sq(b_sq), .den(s_sum), .quo(fb));

    cac_sqrt u_sqrt_a (.aclk(aclk), .en(en), .val(fa), .root(root_a));
    cac_sqrt u_sqrt_b (.aclk(aclk), .en(en), .val(fb), .root(root_b));

    // Delay the control data alongside divider and root stages
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_front;
            for (int i = 1; i < SIDE_DEPTH; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign sd = side_reg[SIDE_DEPTH-1];

    // Round half up: q = floor((isqrt(F) + 1) / 2)
    assign qa = 16'(({1'b0, root_a} + 17'd1) >> 1);
    assign qb = 16'(({1'b0, root_b} + 17'd1) >> 1);

    // Circle side normal with the original signs; zero vector gives zero
    always_comb begin
        if (sd.zero) begin
            cnx = '0;
            cny = '0;
        end else begin
            cnx = sd.neg_x ? -$signed(qa) : $signed(qa);
            cny = sd.neg_y ? -$signed(qb) : $signed(qb);
        end
    end

    // Rectangle side normal from the clamp signs
    always_comb begin
        rmag = (sd.rsx != 2'sd0 && sd.rsy != 2'sd0) ? cac_pkg::DIAG_Q14 : cac_pkg::ONE_Q14;
        if (sd.rsx == 2'sd0)      rnx = '0;
        else if (sd.rsx < 2'sd0)  rnx = -$signed(rmag);
        else                      rnx = $signed(rmag);
        if (sd.rsy == 2'sd0)      rny = '0;
        else if (sd.rsy < 2'sd0)  rny = -$signed(rmag);
        else                      rny = $signed(rmag);
    end

    // Route normals to the sides by pair kind
    always_comb begin
        unique case (sd.cmd)
            cac_pkg::CMD_CIRC_CIRC: begin
                hit_next = sd.hit;
                nax_next = cnx;
                nay_next = cny;
                nbx_next = -cnx;
                nby_next = -cny;
            end
            cac_pkg::CMD_CIRC_RECT: begin
                hit_next = sd.hit;
                nax_next = cnx;
                nay_next = cny;
                nbx_next = rnx;
                nby_next = rny;
            end
            cac_pkg::CMD_RECT_CIRC: begin
                hit_next = sd.hit;
                nax_next = rnx;
                nay_next = rny;
                nbx_next = cnx;
                nby_next = cny;
            end
            default: begin
                hit_next = 1'b0;
                nax_next = '0;
                nay_next = '0;
                nbx_next = '0;
                nby_next = '0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
            nax_reg <= nax_next;
            nay_reg <= nay_next;
            nbx_reg <= nbx_next;
            nby_reg <= nby_next;
        end
    end

    assign m_valid      = vld_reg[LATENCY-1];
    assign m_hit        = hit_reg;
    assign m_normal_a_x = nax_reg;
    assign m_normal_a_y = nay_reg;
    assign m_normal_b_x = nbx_reg;
    assign m_normal_b_y = nby_reg;

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input side stalls exactly when a result is held back
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !(m_valid && !m_ready))
        else $error("input ready does not follow output stall");

    // A held result keeps its a_x and b_y normal components
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_a_x) && $stable(m_normal_b_y))
        else $error("stalled result changed");

    // The a_x and b_y normal components stay within one unit
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_a_x <= 16'sd16384 && m_normal_a_x >= -16'sd16384
                 && m_normal_b_y <= 16'sd16384 && m_normal_b_y >= -16'sd16384)
        else $error("normal component out of range");

endmodule

### sim/cac_checker.sv
// Checker for the circle / rectangle collision test: watches both channels,
// predicts each result from the accepted pair and compares it. Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [31:0] s_circle_x,
    input  logic signed [31:0] s_circle_y,
    input  logic [30:0]        s_circle_r,
    input  logic signed [31:0] s_other_x,
    input  logic signed [31:0] s_other_y,
    input  logic [30:0]        s_other_r,
    input  logic signed [31:0] s_rect_min_x,
    input  logic signed [31:0] s_rect_min_y,
    input  logic signed [31:0] s_rect_max_x,
    input  logic signed [31:0] s_rect_max_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_hit,
    input  logic signed [15:0] m_normal_a_x,
    input  logic signed [15:0] m_normal_a_y,
    input  logic signed [15:0] m_normal_b_x,
    input  logic signed [15:0] m_normal_b_y,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic               hit;
        logic signed [15:0] nax;
        logic signed [15:0] nay;
        logic signed [15:0] nbx;
        logic signed [15:0] nby;
    } contact_t;

    // Ring of predictions waiting for their results
    localparam int DUE_DEPTH = 256;
    contact_t contacts_due [DUE_DEPTH];
    int       wr_cnt, rd_cnt;

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Largest q in 0..16384 with (2q-1)^2 * s <= 2^30 * a^2
    function automatic logic [15:0] unit_part(logic [63:0] a, logic [63:0] s);
        logic [63:0] lo, hi, mid, t;
        logic [127:0] lhs, rhs;
        lo = 0;
        hi = 16384;
        if (a == 0) return 0;
        rhs = {64'd0, a * a} << 30;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(s);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[15:0];
    endfunction

    function automatic void unit_vec(logic signed [63:0] u, logic signed [63:0] v,
                                     output logic signed [15:0] ox,
                                     output logic signed [15:0] oy);
        logic [63:0] a, b, m, s, qa, qb;
        a = abs64(u);
        b = abs64(v);
        m = a > b ? a : b;
        while ((m >> 16) != 0) begin
            a >>= 1;
            b >>= 1;
            m >>= 1;
        end
        s = a * a + b * b;
        ox = 0;
        oy = 0;
        if (s == 0) return;
        qa = unit_part(a, s);
        qb = unit_part(b, s);
        ox = u < 0 ? -16'(qa) : 16'(qa);
        oy = v < 0 ? -16'(qb) : 16'(qb);
    endfunction

    // Exact dx^2 + dy^2 <= r^2
    function automatic logic reaches(logic signed [63:0] dx, logic signed [63:0] dy,
                                     logic [63:0] r);
        logic [127:0] ax, ay;
        ax = abs64(dx);
        ay = abs64(dy);
        return ax * ax + ay * ay <= 128'(r) * 128'(r);
    endfunction

    function automatic contact_t predict_contact();
        contact_t c;
        logic signed [63:0] cx, cy, x, y, sx, sy;
        logic signed [15:0] rnx, rny, cnx, cny;
        cx = s_circle_x;
        cy = s_circle_y;
        c = '0;
        case (cac_pkg::cac_cmd_t'(s_cmd))
            cac_pkg::CMD_CIRC_CIRC: begin
                unit_vec(64'(s_other_x) - cx, 64'(s_other_y) - cy, c.nax, c.nay);
                c.nbx = -c.nax;
                c.nby = -c.nay;
                c.hit = reaches(64'(s_other_x) - cx, 64'(s_other_y) - cy,
                                64'(s_circle_r) + 64'(s_other_r));
            end
            cac_pkg::CMD_CIRC_RECT, cac_pkg::CMD_RECT_CIRC: begin
                x = cx;
                y = cy;
                sx = 0;
                sy = 0;
                // clamp in order: min first, then max
                if (x < s_rect_min_x) begin x = s_rect_min_x; sx = -1; end
                if (x > s_rect_max_x) begin x = s_rect_max_x; sx = 1; end
                if (y < s_rect_min_y) begin y = s_rect_min_y; sy = -1; end
                if (y > s_rect_max_y) begin y = s_rect_max_y; sy = 1; end
                unit_vec(sx, sy, rnx, rny);
                unit_vec(x - cx, y - cy, cnx, cny);
                c.hit = reaches(x - cx, y - cy, 64'(s_circle_r));
                if (cac_pkg::cac_cmd_t'(s_cmd) == cac_pkg::CMD_CIRC_RECT) begin
                    c.nax = cnx; c.nay = cny; c.nbx = rnx; c.nby = rny;
                end else begin
                    c.nax = rnx; c.nay = rny; c.nbx = cnx; c.nby = cny;
                end
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    assign pending = wr_cnt - rd_cnt;

    // Queue predictions on input transactions, compare on output transactions
    always @(posedge aclk) begin
        contact_t want;
        if (!aresetn) begin
            wr_cnt <= 0;
            rd_cnt <= 0;
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                contacts_due[wr_cnt[7:0]] <= predict_contact();
                wr_cnt <= wr_cnt + 1;
            end
            if (m_valid && m_ready) begin
                if (wr_cnt == rd_cnt) begin
                    $error("result with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = contacts_due[rd_cnt[7:0]];
                    rd_cnt <= rd_cnt + 1;
                    if (m_hit !== want.hit || m_normal_a_x !== want.nax ||
                        m_normal_a_y !== want.nay || m_normal_b_x !== want.nbx ||
                        m_normal_b_y !== want.nby)
                        fail_count <= fail_count + 1;
                    if (m_hit !== want.hit)
                        $error("hit: expected %0d actual %0d", want.hit, m_hit);
                    if (m_normal_a_x !== want.nax)
                        $error("normal_a_x: expected %0d actual %0d", want.nax, m_normal_a_x);
                    if (m_normal_a_y !== want.nay)
                        $error("normal_a_y: expected %0d actual %0d", want.nay, m_normal_a_y);
                    if (m_normal_b_x !== want.nbx)
                        $error("normal_b_x: expected %0d actual %0d", want.nbx, m_normal_b_x);
                    if (m_normal_b_y !== want.nby)
                        $error("normal_b_y: expected %0d actual %0d", want.nby, m_normal_b_y);
                end
            end
        end
    end

endmodule

### sim/tb_circle_aabb_collision_test.sv
// Testbench top for circle_aabb_collision_test: drives directed and random shape
// pairs with bursty input and stalling output. Depends on the DUT, cac_pkg and cac_checker.
`timescale 1ns / 1ps

module tb_circle_aabb_collision_test;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, m_valid, m_ready = 0;
    logic [1:0] s_cmd = 0;
    logic signed [31:0] s_circle_x = 0, s_circle_y = 0, s_other_x = 0, s_other_y = 0;
    logic [30:0] s_circle_r = 0, s_other_r = 0;
    logic signed [31:0] s_rect_min_x = 0, s_rect_min_y = 0;
    logic signed [31:0] s_rect_max_x = 0, s_rect_max_y = 0;
    logic m_hit;
    logic signed [15:0] m_normal_a_x, m_normal_a_y, m_normal_b_x, m_normal_b_y;
    int fail_count, pending;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    circle_aabb_collision_test uut (.*);
    cac_checker checker_i (.*);

    // Pick a coordinate: mostly small, sometimes anywhere or at an extreme
    function automatic logic signed [31:0] coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic logic [30:0] radius();
        case ($urandom_range(0, 9))
            0: return 31'($urandom());
            1: return 31'h7fffffff;
            default: return 31'($urandom_range(0, 32'h0007ffff));
        endcase
    endfunction

    // Offer one pair and hold it until accepted
    task automatic send_pair(logic [1:0] cmd, logic signed [31:0] cx, cy,
                             logic [30:0] cr, logic signed [31:0] ox, oy,
                             logic [30:0] orr, logic signed [31:0] x0, y0, x1, y1);
        s_cmd <= cmd;
        s_circle_x <= cx; s_circle_y <= cy; s_circle_r <= cr;
        s_other_x <= ox; s_other_y <= oy; s_other_r <= orr;
        s_rect_min_x <= x0; s_rect_min_y <= y0;
        s_rect_max_x <= x1; s_rect_max_y <= y1;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random(logic [1:0] cmd);
        logic signed [31:0] a, b, c, d;
        a = coord(); b = coord(); c = coord(); d = coord();
        // mostly proper boxes, some inverted
        if ($urandom_range(0, 7) != 0) begin
            if (a > c) begin a ^= c; c ^= a; a ^= c; end
            if (b > d) begin b ^= d; d ^= b; b ^= d; end
        end
        send_pair(cmd, coord(), coord(), radius(), coord(), coord(), radius(), a, b, c, d);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off
    initial begin
        int n;
        n = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            n++;
            if (n > 300 && n <= 500) m_ready <= 0;
            else if ((n / 64) % 3 == 0) m_ready <= 1;
            else m_ready <= $urandom_range(0, 3) != 0;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // Directed: zero vectors, extremes, inverted box, touching circles, every kind
        send_pair(cac_pkg::CMD_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(cac_pkg::CMD_CIRC_CIRC, 0, 0, 31'h10000, 32'h20000, 0, 31'h10000,
                  0, 0, 0, 0);
        send_pair(cac_pkg::CMD_CIRC_CIRC, 32'sh80000000, 32'sh80000000, 31'h7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 0, 0, 0, 0);
        send_pair(cac_pkg::CMD_CIRC_CIRC, 32'sh7fffffff, 32'sh80000000, 0,
                  32'sh80000000, 32'sh7fffffff, 0, -1, -1, -1, -1);
        send_pair(cac_pkg::CMD_CIRC_CIRC, 0, 0, 1, 3, 4, 3, 0, 0, 0, 0);
        send_pair(cac_pkg::CMD_CIRC_CIRC, 0, 0, 1, 3, 4, 4, 0, 0, 0, 0);
        send_pair(cac_pkg::CMD_CIRC_RECT, 5, 5, 1, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_RECT_CIRC, 5, 5, 1, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_CIRC_RECT, -20, -20, 31'h7fffffff, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_RECT_CIRC, 20, -20, 10, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_CIRC_RECT, 20, 5, 10, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_RECT_CIRC, 5, 25, 14, 0, 0, 0, 0, 0, 10, 10);
        send_pair(cac_pkg::CMD_CIRC_RECT, 5, 5, 3, 0, 0, 0, 10, 10, 0, 0);
        send_pair(cac_pkg::CMD_RECT_CIRC, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff,
                  0, 0, 0,
                  32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_pair(cac_pkg::CMD_CIRC_RECT, 32'sh7fffffff, 32'sh7fffffff, 0,
                  -1, -1, 31'h7fffffff,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_pair(cac_pkg::CMD_RECT_RECT, -1, -1, 31'h7fffffff, -1, -1, 31'h7fffffff,
                  -1, -1, -1, -1);
        send_pair(cac_pkg::CMD_RECT_RECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Random bursts with random gaps
        for (int i = 0; i < 1100; ) begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++, i++)
                send_random(2'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        if (fail_count == 0 && !m_valid)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
